### src/mpg_pkg.sv
// Shared types, codes and constants of the memory pressure governor.
`default_nettype none

package mpg_pkg;

    typedef logic [16:0] frac_t;
    typedef logic [23:0] horizon_t;

    localparam frac_t    FRAC_ONE        = 17'd65536;
    localparam frac_t    BATT_ESCROW_MIN = 17'd13107;
    localparam frac_t    BATT_LOW        = 17'd6554;
    localparam logic [11:0] SNR_LOW      = 12'd1280;
    localparam logic [11:0] SNR_HIGH     = 12'd2560;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HORIZON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HORIZON     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DETAIL     = 3'd4;

    localparam horizon_t   RST_DEFAULT_HORIZON = 24'd15360;
    localparam horizon_t   RST_MIN_HORIZON     = 24'd2560;
    localparam frac_t      RST_WARNING_LEVEL   = 17'd45875;
    localparam frac_t      RST_CRITICAL_LEVEL  = 17'd58982;
    localparam logic [3:0] RST_BASE_DETAIL     = 4'd2;

    localparam logic [1:0] MODE_NOMINAL  = 2'd0;
    localparam logic [1:0] MODE_WARNING  = 2'd1;
    localparam logic [1:0] MODE_CRITICAL = 2'd2;

    // Quotient bits produced by the divider for the horizon and for the SNR ramp.
    localparam logic [4:0] HZ_STEPS  = 5'd24;
    localparam logic [4:0] SNR_STEPS = 5'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_MUL,
        ST_HSTART,
        ST_HWAIT,
        ST_SSTART,
        ST_SWAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       start;
        logic [4:0] steps;
        frac_t      rem_init;
        horizon_t   dvd_init;
        frac_t      divisor;
    } div_req_t;

    typedef struct packed {
        logic     busy;
        logic     done;
        horizon_t quotient;
    } div_stat_t;

    function automatic frac_t sat_frac(input frac_t v);
        return (v > FRAC_ONE) ? FRAC_ONE : v;
    endfunction

endpackage

`default_nettype wire

### src/mpg_if.sv
// Channel interfaces of the memory pressure governor: telemetry, policy and configuration.
`default_nettype none

interface mpg_tel_if import mpg_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  free_valid;
    frac_t free_memory;
    logic  battery_valid;
    frac_t battery_level;

    modport source (output valid, free_valid, free_memory, battery_valid, battery_level,
                    input ready);
    modport sink   (input valid, free_valid, free_memory, battery_valid, battery_level,
                    output ready);
endinterface

interface mpg_pol_if import mpg_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    horizon_t    horizon;
    logic [4:0]  detail_floor;
    logic [11:0] snr_limit;
    logic        escrow_allowed;
    logic        purge_now;

    modport source (output valid, mode, horizon, detail_floor, snr_limit,
                    escrow_allowed, purge_now, input ready);
    modport sink   (input valid, mode, horizon, detail_floor, snr_limit,
                    escrow_allowed, purge_now, output ready);
endinterface

interface mpg_cfg_if import mpg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/memory_pressure_governor.sv
// Top level of the memory pressure governor: stores, band sequencer and policy output.
//
//   channel     dir   payload                                          accepted when
//   telemetry   in    free_valid, free_memory, battery_valid, level    valid && ready
//   policy      out   mode, horizon, detail, snr, escrow, purge        valid && ready
//   cfg         in    index (3 bits), data (24 bits)                   valid && ready
//
// In the warning band a telemetry transaction runs the serial divider, one quotient bit
// per cycle, 24 bits for the horizon and 9 bits for the SNR ramp, one after the other.
// When the default horizon is not above the minimum only the SNR divide runs. The other
// bands skip the divider and go from classification straight to the finish state.
// The telemetry channel is not ready while a transaction is in work.
// A finished result sits in the policy output register and waits there for ready;
// the next telemetry transaction may be taken while it waits, and a second finished
// result holds the sequencer until the register frees up.
// Reset clears the stores to full memory and full battery and loads register defaults.
`default_nettype none

module memory_pressure_governor
    import mpg_pkg::*;
(
    input  wire clk,
    input  wire rst_n,
    mpg_tel_if.sink   telemetry,
    mpg_pol_if.source policy,
    mpg_cfg_if.sink   cfg
);

    state_t state_reg, state_next;

    horizon_t   default_horizon_reg;
    horizon_t   min_horizon_reg;
    frac_t      warning_level_reg;
    frac_t      critical_level_reg;
    logic [3:0] base_detail_reg;

    frac_t free_store_reg;
    frac_t battery_store_reg;

    logic [1:0]  mode_reg;
    frac_t       d_reg;
    frac_t       s_reg;
    logic [40:0] prod_reg;
    horizon_t    hz_reg;
    logic [11:0] snr_reg;

    logic        out_valid_reg;
    logic [1:0]  out_mode_reg;
    horizon_t    out_horizon_reg;
    logic [4:0]  out_detail_reg;
    logic [11:0] out_snr_reg;
    logic        out_escrow_reg;
    logic        out_purge_reg;

    div_req_t  div_req;
    div_stat_t div_stat;

    logic     tel_accept;
    logic     cls_load;
    logic     mul_load;
    logic     hz_load;
    logic     snr_load;
    logic     out_load;
    logic     out_free;
    logic     span_pos;
    frac_t    used;
    horizon_t hz_span;

    logic [4:0] detail_w;
    logic       escrow_w;

    mpg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    assign used       = 17'(FRAC_ONE - free_store_reg);
    assign span_pos   = (default_horizon_reg > min_horizon_reg);
    assign hz_span    = 24'(default_horizon_reg - min_horizon_reg);
    assign out_free   = !out_valid_reg || policy.ready;
    assign tel_accept = telemetry.valid && telemetry.ready;
    assign cfg.ready  = 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (telemetry.valid)
                    state_next = ST_CLASSIFY;
            ST_CLASSIFY:
                if (used >= warning_level_reg && used < critical_level_reg)
                    state_next = ST_MUL;
                else
                    state_next = ST_FINISH;
            ST_MUL:
                state_next = span_pos ? ST_HSTART : ST_SSTART;
            ST_HSTART:
                state_next = ST_HWAIT;
            ST_HWAIT:
                if (div_stat.done)
                    state_next = ST_SSTART;
            ST_SSTART:
                state_next = ST_SWAIT;
            ST_SWAIT:
                if (div_stat.done)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        telemetry.ready  = 1'b0;
        cls_load         = 1'b0;
        mul_load         = 1'b0;
        hz_load          = 1'b0;
        snr_load         = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.steps    = HZ_STEPS;
        div_req.rem_init = prod_reg[40:24];
        div_req.dvd_init = prod_reg[23:0];
        div_req.divisor  = s_reg;
        unique case (state_reg)
            ST_IDLE:
                telemetry.ready = 1'b1;
            ST_CLASSIFY:
                cls_load = 1'b1;
            ST_MUL:
                mul_load = 1'b1;
            ST_HSTART:
                div_req.start = 1'b1;
            ST_HWAIT:
                hz_load = div_stat.done;
            ST_SSTART:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = SNR_STEPS;
                div_req.rem_init = d_reg;
                div_req.dvd_init = '0;
            end
            ST_SWAIT:
                snr_load = div_stat.done;
            ST_FINISH:
                out_load = out_free;
            default:
                telemetry.ready = 1'b0;
        endcase
    end

    // Detail floor and escrow permit of the finished transaction.
    always_comb
    begin
        detail_w = 5'd1;
        escrow_w = 1'b1;
        unique case (mode_reg)
            MODE_WARNING:
                detail_w = {1'b0, base_detail_reg};
            MODE_CRITICAL:
            begin
                detail_w = 5'({1'b0, base_detail_reg} + 5'd1);
                escrow_w = (battery_store_reg > BATT_ESCROW_MIN);
            end
            default:
                detail_w = 5'd1;
        endcase
        if (battery_store_reg < BATT_LOW)
        begin
            escrow_w = 1'b0;
            if (detail_w < 5'd2)
                detail_w = 5'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            default_horizon_reg <= RST_DEFAULT_HORIZON;
            min_horizon_reg     <= RST_MIN_HORIZON;
            warning_level_reg   <= RST_WARNING_LEVEL;
            critical_level_reg  <= RST_CRITICAL_LEVEL;
            base_detail_reg     <= RST_BASE_DETAIL;
            free_store_reg      <= FRAC_ONE;
            battery_store_reg   <= FRAC_ONE;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_DEFAULT_HORIZON: default_horizon_reg <= cfg.data;
                    CFG_MIN_HORIZON:     min_horizon_reg     <= cfg.data;
                    CFG_WARNING_LEVEL:   warning_level_reg   <= cfg.data[16:0];
                    CFG_CRITICAL_LEVEL:  critical_level_reg  <= cfg.data[16:0];
                    CFG_BASE_DETAIL:     base_detail_reg     <= cfg.data[3:0];
                    default:             ;
                endcase
            end
            if (tel_accept && telemetry.free_valid)
                free_store_reg <= sat_frac(telemetry.free_memory);
            if (tel_accept && telemetry.battery_valid)
                battery_store_reg <= sat_frac(telemetry.battery_level);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (policy.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_load)
        begin
            d_reg <= 17'(used - warning_level_reg);
            s_reg <= 17'(critical_level_reg - warning_level_reg);
            if (used < warning_level_reg)
            begin
                mode_reg <= MODE_NOMINAL;
                hz_reg   <= default_horizon_reg;
                snr_reg  <= SNR_LOW;
            end
            else if (used < critical_level_reg)
            begin
                mode_reg <= MODE_WARNING;
            end
            else
            begin
                mode_reg <= MODE_CRITICAL;
                hz_reg   <= min_horizon_reg;
                snr_reg  <= SNR_HIGH;
            end
        end
        if (mul_load)
        begin
            prod_reg <= 41'(d_reg) * 41'(hz_span);
            if (!span_pos)
                hz_reg <= min_horizon_reg;
        end
        // d < s, so the product's upper bits are a valid starting remainder
        // and the quotient is below the horizon span.
        if (hz_load)
            hz_reg <= 24'(default_horizon_reg - div_stat.quotient);
        if (snr_load)
            snr_reg <= 12'(SNR_LOW + {3'b000, div_stat.quotient[8:0]});
        if (out_load)
        begin
            out_mode_reg    <= mode_reg;
            out_horizon_reg <= hz_reg;
            out_detail_reg  <= detail_w;
            out_snr_reg     <= snr_reg;
            out_escrow_reg  <= escrow_w;
            out_purge_reg   <= (mode_reg == MODE_CRITICAL);
        end
    end

    assign policy.valid           = out_valid_reg;
    assign policy.mode            = out_mode_reg;
    assign policy.horizon         = out_horizon_reg;
    assign policy.detail_floor    = out_detail_reg;
    assign policy.snr_limit       = out_snr_reg;
    assign policy.escrow_allowed  = out_escrow_reg;
    assign policy.purge_now       = out_purge_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tel_accept |=> !telemetry.ready)
        else $error("telemetry ready right after an accepted transaction");

    a_purge_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        policy.valid |-> (policy.purge_now == (policy.mode == MODE_CRITICAL)))
        else $error("purge flag disagrees with mode");

    a_snr_range: assert property (@(posedge clk) disable iff (!rst_n)
        policy.valid |-> (policy.snr_limit >= SNR_LOW && policy.snr_limit <= SNR_HIGH))
        else $error("SNR limit out of range");

    a_div_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FINISH) |-> !div_stat.busy)
        else $error("divider busy outside the interpolation states");

    a_low_battery_escrow: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && battery_store_reg < BATT_LOW |=> !policy.escrow_allowed)
        else $error("escrow granted on low battery");

endmodule

`default_nettype wire

### src/mpg_div.sv
// Bit-serial restoring divider shared by the horizon and SNR interpolation.
`default_nettype none

module mpg_div
    import mpg_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic [4:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;
    frac_t      rem_reg, rem_next;
    horizon_t   sh_reg, sh_next;

    logic [17:0] cat;
    logic [17:0] dvs;
    logic        ge;

    // The partial remainder is always below the divisor, so one shifted-in bit
    // keeps it below twice the divisor and a single subtract restores it.
    always_comb
    begin
        cat = {rem_reg, sh_reg[23]};
        dvs = {1'b0, req.divisor};
        ge  = (cat >= dvs);
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        if (req.start)
        begin
            cnt_next = req.steps;
            rem_next = req.rem_init;
            sh_next  = req.dvd_init;
        end
        else if (cnt_reg != 5'd0)
        begin
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
            rem_next  = ge ? 17'(cat - dvs) : cat[16:0];
            sh_next   = {sh_reg[22:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign stat.busy     = (cnt_reg != 5'd0);
    assign stat.done     = done_reg;
    assign stat.quotient = sh_reg;

endmodule

`default_nettype wire

### bench/tb_memory_pressure_governor.sv
// Self-checking testbench for the memory pressure governor, with an in-bench policy predictor.
module tb_memory_pressure_governor
    import mpg_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned RESET_CYCLES    = 8;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned DRAIN_CYCLES    = 60;
    localparam int unsigned MAX_GAP         = 20;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned CHUNKS_PER_PASS = 4;
    localparam int unsigned CHUNK_ITEMS     = 65;
    localparam int unsigned STALL_CYCLES    = 400;
    localparam int unsigned STALL_ITEMS     = 24;

    localparam logic [11:0] SNR_RAMP        = 12'd512;
    localparam logic [4:0]  DETAIL_NOMINAL  = 5'd1;
    localparam logic [4:0]  DETAIL_LOW_BATT = 5'd2;
    localparam frac_t       FRAC_MAX_RAW    = 17'h1FFFF;
    localparam horizon_t    HORIZON_MAX     = 24'hFFFFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_BASE_DETAIL + 1'b1;

    typedef struct packed {
        horizon_t   dflt;
        horizon_t   minh;
        frac_t      warn;
        frac_t      crit;
        logic [3:0] base;
    } gov_regs_t;

    typedef struct packed {
        logic  free_valid;
        frac_t free_memory;
        logic  battery_valid;
        frac_t battery_level;
    } telemetry_t;

    typedef struct packed {
        logic [1:0]  mode;
        horizon_t    horizon;
        logic [4:0]  detail_floor;
        logic [11:0] snr_limit;
        logic        escrow_allowed;
        logic        purge_now;
    } policy_t;

    logic clk;
    logic rst_n;

    mpg_tel_if tel ();
    mpg_pol_if pol ();
    mpg_cfg_if cfg_ch ();

    memory_pressure_governor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .telemetry (tel),
        .policy    (pol),
        .cfg       (cfg_ch)
    );

    // Predictor state: register copy and the two stored fractions.
    gov_regs_t   gov_regs;
    frac_t       free_frac;
    frac_t       battery_frac;
    policy_t     policy_due[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_hold;
    int unsigned fail_count;
    int unsigned results_seen;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[memory_pressure_governor] ERROR");
            $finish;
        end
    end

    function automatic frac_t saturate(input frac_t v);
        return (v > FRAC_ONE) ? FRAC_ONE : v;
    endfunction

    function automatic policy_t derive_policy();
        policy_t           p;
        frac_t             used;
        longint unsigned   d;
        longint unsigned   s;
        longint unsigned   drop;
        used = FRAC_ONE - free_frac;
        if (used < gov_regs.warn)
        begin
            p.mode            = MODE_NOMINAL;
            p.horizon         = gov_regs.dflt;
            p.detail_floor    = DETAIL_NOMINAL;
            p.snr_limit       = SNR_LOW;
            p.escrow_allowed  = 1'b1;
            p.purge_now       = 1'b0;
        end
        else if (used < gov_regs.crit)
        begin
            d = longint'(used - gov_regs.warn);
            s = longint'(gov_regs.crit - gov_regs.warn);
            p.mode = MODE_WARNING;
            if (gov_regs.dflt > gov_regs.minh)
            begin
                drop = (d * longint'(gov_regs.dflt - gov_regs.minh)) / s;
                p.horizon = gov_regs.dflt - horizon_t'(drop);
            end
            else
            begin
                p.horizon = gov_regs.minh;
            end
            p.detail_floor   = {1'b0, gov_regs.base};
            p.snr_limit      = SNR_LOW + 12'((d * SNR_RAMP) / s);
            p.escrow_allowed = 1'b1;
            p.purge_now      = 1'b0;
        end
        else
        begin
            p.mode            = MODE_CRITICAL;
            p.horizon         = gov_regs.minh;
            p.detail_floor    = {1'b0, gov_regs.base} + 5'd1;
            p.snr_limit       = SNR_HIGH;
            p.escrow_allowed  = battery_frac > BATT_ESCROW_MIN;
            p.purge_now       = 1'b1;
        end
        if (battery_frac < BATT_LOW)
        begin
            p.escrow_allowed = 1'b0;
            if (p.detail_floor < DETAIL_LOW_BATT)
                p.detail_floor = DETAIL_LOW_BATT;
        end
        return p;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
            note_failure($sformatf("policy #%0d %s: expected %0d, got %0d",
                                   results_seen, name, want, got));
    endtask

    // Result checker: every policy transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin
        policy_t want;
        if (rst_n && pol.valid && pol.ready)
        begin
            results_seen++;
            if (policy_due.size() == 0)
            begin
                note_failure($sformatf("policy #%0d arrived with none expected", results_seen));
            end
            else
            begin
                want = policy_due.pop_front();
                check_field("mode", want.mode, pol.mode);
                check_field("horizon", want.horizon, pol.horizon);
                check_field("detail_floor", want.detail_floor, pol.detail_floor);
                check_field("snr_limit", want.snr_limit, pol.snr_limit);
                check_field("escrow_allowed", want.escrow_allowed, pol.escrow_allowed);
                check_field("purge_now", want.purge_now, pol.purge_now);
            end
        end
    end

    // Policy receiver: random stalls, plus a long hold-off counted down here when requested.
    initial
    begin
        pol.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_hold > 0)
            begin
                pol.ready <= 1'b0;
                stall_hold = stall_hold - 1;
            end
            else
            begin
                pol.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_telemetry(input telemetry_t t);
        int unsigned gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < MAX_GAP)
        begin
            tel.valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        tel.valid         <= 1'b1;
        tel.free_valid    <= t.free_valid;
        tel.free_memory   <= t.free_memory;
        tel.battery_valid <= t.battery_valid;
        tel.battery_level <= t.battery_level;
        do
            @(posedge clk);
        while (!tel.ready);
        if (t.free_valid)
            free_frac = saturate(t.free_memory);
        if (t.battery_valid)
            battery_frac = saturate(t.battery_level);
        policy_due.push_back(derive_policy());
    endtask

    // Lowers valid in the same step as the last acceptance, so nothing is taken twice.
    task automatic release_telemetry();
        tel.valid <= 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_DEFAULT_HORIZON: gov_regs.dflt = value;
            CFG_MIN_HORIZON:     gov_regs.minh = value;
            CFG_WARNING_LEVEL:   gov_regs.warn = value[16:0];
            CFG_CRITICAL_LEVEL:  gov_regs.crit = value[16:0];
            CFG_BASE_DETAIL:     gov_regs.base = value[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_for_idle();
        while (policy_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reconfigure(input gov_regs_t r);
        wait_for_idle();
        write_register(CFG_DEFAULT_HORIZON, r.dflt);
        write_register(CFG_MIN_HORIZON, r.minh);
        write_register(CFG_WARNING_LEVEL, CFG_DATA_W'(r.warn));
        write_register(CFG_CRITICAL_LEVEL, CFG_DATA_W'(r.crit));
        write_register(CFG_BASE_DETAIL, CFG_DATA_W'(r.base));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic telemetry_t tele(input logic fv, input frac_t fm,
                                        input logic bv, input frac_t bl);
        telemetry_t t;
        t.free_valid    = fv;
        t.free_memory   = fm;
        t.battery_valid = bv;
        t.battery_level = bl;
        return t;
    endfunction

    function automatic gov_regs_t regs_of(input horizon_t dflt, input horizon_t minh,
                                          input frac_t warn, input frac_t crit,
                                          input logic [3:0] base);
        gov_regs_t r;
        r.dflt = dflt;
        r.minh = minh;
        r.warn = warn;
        r.crit = crit;
        r.base = base;
        return r;
    endfunction

    // Free memory biased toward the warning band and the band boundaries.
    function automatic frac_t pick_free();
        int unsigned pick;
        int          used;
        pick = $urandom_range(9);
        if (pick < 4 && gov_regs.crit > gov_regs.warn)
            used = gov_regs.warn + $urandom_range(gov_regs.crit - gov_regs.warn - 1);
        else if (pick < 6)
            used = ($urandom_range(1) ? int'(gov_regs.warn) : int'(gov_regs.crit))
                   + int'($urandom_range(2)) - 1;
        else if (pick < 7)
            return frac_t'($urandom_range(FRAC_MAX_RAW, FRAC_ONE + 1));
        else
            return frac_t'($urandom_range(FRAC_ONE));
        if (used < 0)
            used = 0;
        if (used > int'(FRAC_ONE))
            used = FRAC_ONE;
        return FRAC_ONE - frac_t'(used);
    endfunction

    function automatic frac_t pick_battery();
        case ($urandom_range(7))
            0, 1:    return frac_t'(BATT_LOW - 2 + $urandom_range(4));
            2, 3:    return frac_t'(BATT_ESCROW_MIN - 2 + $urandom_range(4));
            4:       return frac_t'($urandom_range(FRAC_MAX_RAW, FRAC_ONE + 1));
            5:       return $urandom_range(1) ? FRAC_ONE : frac_t'(0);
            default: return frac_t'($urandom_range(FRAC_ONE));
        endcase
    endfunction

    function automatic telemetry_t random_telemetry();
        telemetry_t t;
        t.free_valid    = ($urandom_range(99) < 85);
        t.free_memory   = t.free_valid ? pick_free() : frac_t'($urandom());
        t.battery_valid = ($urandom_range(99) < 45);
        t.battery_level = t.battery_valid ? pick_battery() : frac_t'($urandom());
        return t;
    endfunction

    function automatic gov_regs_t random_regs();
        gov_regs_t   r;
        frac_t       a;
        frac_t       b;
        int unsigned pick;
        r.dflt = ($urandom_range(3) == 0) ? horizon_t'($urandom())
                                          : horizon_t'($urandom_range(65535));
        r.minh = ($urandom_range(4) == 0) ? horizon_t'($urandom())
                                          : horizon_t'($urandom_range(r.dflt));
        a = frac_t'($urandom_range(FRAC_ONE));
        b = frac_t'($urandom_range(FRAC_ONE));
        pick = $urandom_range(9);
        if (pick < 7)
        begin
            r.warn = (a < b) ? a : b;
            r.crit = (a < b) ? b : a;
        end
        else if (pick == 7)
        begin
            r.warn = a;
            r.crit = a;
        end
        else if (pick == 8)
        begin
            r.warn = (a < b) ? b : a;
            r.crit = (a < b) ? a : b;
        end
        else
        begin
            r.warn = 0;
            r.crit = FRAC_ONE;
        end
        r.base = 4'($urandom_range(15));
        return r;
    endfunction

    task automatic test_bands_at_reset();
        send_telemetry(tele(1'b0, FRAC_MAX_RAW, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, FRAC_ONE - gov_regs.warn, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, FRAC_ONE - gov_regs.warn + 1'b1, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, FRAC_ONE - gov_regs.crit + 1'b1, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, FRAC_ONE - gov_regs.crit, 1'b0, 17'd0));
        // Escrow in the critical band flips just above the 0.2 battery mark.
        send_telemetry(tele(1'b0, 17'd0, 1'b1, BATT_ESCROW_MIN));
        send_telemetry(tele(1'b0, 17'd0, 1'b1, BATT_ESCROW_MIN + 1'b1));
        send_telemetry(tele(1'b1, 17'd0, 1'b1, BATT_LOW - 1'b1));
        send_telemetry(tele(1'b1, FRAC_MAX_RAW, 1'b0, 17'd0));
        send_telemetry(tele(1'b0, 17'd0, 1'b1, BATT_LOW));
        send_telemetry(tele(1'b0, 17'd0, 1'b1, FRAC_MAX_RAW));
        send_telemetry(tele(1'b1, 17'd70000, 1'b1, 17'd0));
        release_telemetry();
    endtask

    task automatic test_register_extremes();
        logic [CFG_IDX_W-1:0] idx;
        reconfigure(regs_of(HORIZON_MAX, 24'd0, 17'd0, FRAC_ONE, 4'd15));
        send_telemetry(tele(1'b1, FRAC_ONE, 1'b1, FRAC_ONE));
        send_telemetry(tele(1'b1, 17'd1, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, 17'd32768, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, 17'd0, 1'b0, 17'd0));
        release_telemetry();
        // Default horizon below the minimum clamps to the minimum in the warning band.
        reconfigure(regs_of(24'd1000, 24'd5000, 17'd100, 17'd200, 4'd0));
        send_telemetry(tele(1'b1, FRAC_ONE - 17'd150, 1'b1, FRAC_ONE));
        send_telemetry(tele(1'b0, 17'd0, 1'b1, 17'd0));
        release_telemetry();
        reconfigure(regs_of(24'd5000, 24'd5000, 17'd100, 17'd200, 4'd1));
        send_telemetry(tele(1'b1, FRAC_ONE - 17'd199, 1'b1, FRAC_ONE));
        release_telemetry();
        // Empty and inverted warning bands.
        reconfigure(regs_of(24'd9000, 24'd300, 17'd40000, 17'd40000, 4'd5));
        send_telemetry(tele(1'b1, FRAC_ONE - 17'd39999, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, FRAC_ONE - 17'd40000, 1'b0, 17'd0));
        release_telemetry();
        reconfigure(regs_of(24'd9000, 24'd300, 17'd60000, 17'd30000, 4'd5));
        send_telemetry(tele(1'b1, FRAC_ONE - 17'd45000, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, FRAC_ONE - 17'd60000, 1'b0, 17'd0));
        release_telemetry();
        reconfigure(regs_of(24'd777, 24'd11, FRAC_ONE, FRAC_ONE, 4'd3));
        send_telemetry(tele(1'b1, 17'd0, 1'b0, 17'd0));
        send_telemetry(tele(1'b1, 17'd1, 1'b0, 17'd0));
        release_telemetry();
        reconfigure(regs_of(24'd777, 24'd11, 17'd0, 17'd0, 4'd3));
        send_telemetry(tele(1'b1, FRAC_ONE, 1'b0, 17'd0));
        release_telemetry();
        // Writes to indexes past the last register must leave every register alone.
        wait_for_idle();
        idx = CFG_FIRST_UNUSED;
        repeat ((1 << CFG_IDX_W) - CFG_FIRST_UNUSED)
        begin
            write_register(idx, CFG_DATA_W'($urandom()));
            idx++;
        end
        cfg_ch.valid <= 1'b0;
        send_telemetry(tele(1'b1, 17'd0, 1'b1, 17'd20000));
        release_telemetry();
    endtask

    task automatic test_random_pass(input int unsigned send_pct, input int unsigned recv_pct);
        wait_for_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (CHUNKS_PER_PASS)
        begin
            reconfigure(random_regs());
            repeat (CHUNK_ITEMS) send_telemetry(random_telemetry());
            release_telemetry();
        end
    endtask

    task automatic test_output_backpressure();
        reconfigure(regs_of(RST_DEFAULT_HORIZON, RST_MIN_HORIZON, RST_WARNING_LEVEL,
                            RST_CRITICAL_LEVEL, RST_BASE_DETAIL));
        send_idle_pct = 0;
        stall_hold    = STALL_CYCLES;
        repeat (STALL_ITEMS) send_telemetry(random_telemetry());
        release_telemetry();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        tel.valid          = 1'b0;
        tel.free_valid     = 1'b0;
        tel.free_memory    = '0;
        tel.battery_valid  = 1'b0;
        tel.battery_level  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        cycle_count        = 0;
        fail_count         = 0;
        results_seen       = 0;
        stall_hold         = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        gov_regs     = regs_of(RST_DEFAULT_HORIZON, RST_MIN_HORIZON, RST_WARNING_LEVEL,
                               RST_CRITICAL_LEVEL, RST_BASE_DETAIL);
        free_frac    = FRAC_ONE;
        battery_frac = FRAC_ONE;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 70;
        test_bands_at_reset();
        test_register_extremes();
        test_random_pass(37, 70);
        test_output_backpressure();
        test_random_pass(70, 37);
        test_random_pass(0, 0);

        while (policy_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && policy_due.size() == 0)
            $display("[memory_pressure_governor] OK");
        else
            $display("[memory_pressure_governor] ERROR");
        $finish;
    end

endmodule

### memory_pressure_governor.f
src/mpg_pkg.sv
src/mpg_if.sv
src/mpg_div.sv
src/memory_pressure_governor.sv
bench/tb_memory_pressure_governor.sv
